### design/xfm_pkg.sv
// shared constants and types for the x25519 field multiplier
`timescale 1ns / 1ps

package xfm_pkg;

  // limb and digit geometry
  localparam int LIMB_W    = 64;
  localparam int NUM_LIMBS = 4;
  localparam int DIGIT_W   = 32;
  localparam int NUM_DIG   = 8;
  localparam int NUM_PP    = NUM_DIG * NUM_DIG;
  localparam int NUM_COL   = 2 * NUM_DIG - 1;
  localparam int COL_W     = 2 * DIGIT_W + 3;
  localparam int ELEM_W    = LIMB_W * NUM_LIMBS;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int FOLD_W    = ELEM_W + 6;

  // 2^256 is congruent to this modulo 2^255-19
  localparam logic [5:0] FOLD_FACTOR = 6'd38;

  typedef logic [2*DIGIT_W-1:0] pp_t;
  typedef logic [COL_W-1:0]     col_t;

endpackage

### design/xfm_mul.sv
// partial products and column sums of the 512-bit product
`timescale 1ns / 1ps

module xfm_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  logic [xfm_pkg::ELEM_W-1:0]  f_flat,
  input  logic [xfm_pkg::ELEM_W-1:0]  g_flat,
  output logic                        valid_out,
  output xfm_pkg::col_t               col [xfm_pkg::NUM_COL]
);

  xfm_pkg::pp_t  pp      [xfm_pkg::NUM_PP];
  xfm_pkg::pp_t  pp_next [xfm_pkg::NUM_PP];
  xfm_pkg::col_t col_next [xfm_pkg::NUM_COL];
  logic          pp_valid;

  // 32 by 32 digit products
  always_comb begin
    for (int a = 0; a < xfm_pkg::NUM_DIG; a++) begin
      for (int b = 0; b < xfm_pkg::NUM_DIG; b++) begin
        pp_next[a*xfm_pkg::NUM_DIG+b] =
          xfm_pkg::pp_t'(f_flat[a*xfm_pkg::DIGIT_W +: xfm_pkg::DIGIT_W]) *
          xfm_pkg::pp_t'(g_flat[b*xfm_pkg::DIGIT_W +: xfm_pkg::DIGIT_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= valid_in;
    end
    for (int i = 0; i < xfm_pkg::NUM_PP; i++) pp[i] <= pp_next[i];
  end

  // sum the products of equal weight
  always_comb begin
    for (int c = 0; c < xfm_pkg::NUM_COL; c++) begin
      col_next[c] = '0;
      for (int a = 0; a < xfm_pkg::NUM_DIG; a++) begin
        for (int b = 0; b < xfm_pkg::NUM_DIG; b++) begin
          if (a + b == c) begin
            col_next[c] = col_next[c] + {3'b000, pp[a*xfm_pkg::NUM_DIG+b]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= pp_valid;
    end
    for (int c = 0; c < xfm_pkg::NUM_COL; c++) col[c] <= col_next[c];
  end

endmodule

### design/xfm_carry.sv
// carry resolution of the column sums into the full product
`timescale 1ns / 1ps

module xfm_carry (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  xfm_pkg::col_t               col [xfm_pkg::NUM_COL],
  output logic                        valid_out,
  output logic [xfm_pkg::PROD_W-1:0]  prod
);

  localparam int EXT_W = xfm_pkg::PROD_W + 2 * xfm_pkg::LIMB_W;

  logic [EXT_W-1:0]          ev_lo, ev_hi, od_lo, od_hi;
  logic [xfm_pkg::PROD_W-1:0] prod_next;

  // even and odd columns laid out as non-overlapping words
  always_comb begin
    ev_lo = '0;
    ev_hi = '0;
    od_lo = '0;
    od_hi = '0;
    for (int c = 0; c < xfm_pkg::NUM_COL; c++) begin
      if (c % 2 == 0) begin
        ev_lo[c*xfm_pkg::DIGIT_W +: 2*xfm_pkg::DIGIT_W] = col[c][2*xfm_pkg::DIGIT_W-1:0];
        ev_hi[c*xfm_pkg::DIGIT_W + 2*xfm_pkg::DIGIT_W +: 3] =
          col[c][xfm_pkg::COL_W-1 -: 3];
      end else begin
        od_lo[c*xfm_pkg::DIGIT_W +: 2*xfm_pkg::DIGIT_W] = col[c][2*xfm_pkg::DIGIT_W-1:0];
        od_hi[c*xfm_pkg::DIGIT_W + 2*xfm_pkg::DIGIT_W +: 3] =
          col[c][xfm_pkg::COL_W-1 -: 3];
      end
    end
    prod_next = ev_lo[xfm_pkg::PROD_W-1:0] + ev_hi[xfm_pkg::PROD_W-1:0] +
                od_lo[xfm_pkg::PROD_W-1:0] + od_hi[xfm_pkg::PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    prod <= prod_next;
  end

endmodule

### design/xfm_fold.sv
// three folds of the product by 38 back into four limbs
`timescale 1ns / 1ps

module xfm_fold (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  logic [xfm_pkg::PROD_W-1:0]  prod,
  output logic                        valid_out,
  output logic [xfm_pkg::ELEM_W-1:0]  result
);

  logic [xfm_pkg::FOLD_W-1:0] t, t_next;
  logic [xfm_pkg::ELEM_W:0]   u, u_next;
  logic [xfm_pkg::ELEM_W-1:0] result_next;
  logic [xfm_pkg::ELEM_W-1:0] hi_part;
  logic [11:0]                fold2;
  logic                       t_valid, u_valid;

  // first fold: low half plus 38 times the high half, exact
  always_comb begin
    hi_part = prod[xfm_pkg::PROD_W-1 -: xfm_pkg::ELEM_W];
    t_next  = {6'd0, prod[xfm_pkg::ELEM_W-1:0]} +
              ({6'd0, hi_part} << 5) + ({6'd0, hi_part} << 2) + ({6'd0, hi_part} << 1);
  end

  // second fold: six overflow bits times 38
  always_comb begin
    fold2  = {6'd0, t[xfm_pkg::FOLD_W-1 -: 6]} * {6'd0, xfm_pkg::FOLD_FACTOR};
    u_next = {1'b0, t[xfm_pkg::ELEM_W-1:0]} + {{(xfm_pkg::ELEM_W-11){1'b0}}, fold2};
  end

  // third fold: last carry bit times 38, cannot carry out
  always_comb begin
    result_next = u[xfm_pkg::ELEM_W-1:0] +
                  {{(xfm_pkg::ELEM_W-6){1'b0}}, (u[xfm_pkg::ELEM_W] ? xfm_pkg::FOLD_FACTOR : 6'd0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid   <= 1'b0;
      u_valid   <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      t_valid   <= valid_in;
      u_valid   <= t_valid;
      valid_out <= u_valid;
    end
    t      <= t_next;
    u      <= u_next;
    result <= result_next;
  end

`ifndef SYNTHESIS
  // every item leaves after passing the t, u and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst) valid_in |-> ##3 valid_out)
    else $error("fold latency broken");
  // no item appears from nowhere
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> $past(valid_in, 3))
    else $error("fold emitted an item not fed in");
  // a carry out of the second fold leaves a small low word
  a_small_after_carry: assert property (@(posedge clk) disable iff (rst)
    (u_valid && u[xfm_pkg::ELEM_W]) |-> (u[xfm_pkg::ELEM_W-1:12] == '0))
    else $error("second fold carry with large remainder");
`endif

endmodule

### design/x25519_field_multiply_core.sv
// top level of the pipelined x25519 field multiplier
`timescale 1ns / 1ps

// Multiplies two 256-bit field elements modulo 2^255-19 in radix 2^64 and
// returns four limbs below 2^256 congruent to f*g (not fully reduced). One
// item is taken every cycle; busy is always low. The result appears on the
// product ports with done high once it has passed the six register stages:
// digit products, column sums, carry resolution and three folds by 38. The
// receiver cannot stall, so results must be taken in the cycle done is high.

module x25519_field_multiply_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] f_limb0,
  input  logic [63:0] f_limb1,
  input  logic [63:0] f_limb2,
  input  logic [63:0] f_limb3,
  input  logic [63:0] g_limb0,
  input  logic [63:0] g_limb1,
  input  logic [63:0] g_limb2,
  input  logic [63:0] g_limb3,
  output logic        done,
  output logic [63:0] product_limb0,
  output logic [63:0] product_limb1,
  output logic [63:0] product_limb2,
  output logic [63:0] product_limb3
);

  xfm_pkg::col_t              col [xfm_pkg::NUM_COL];
  logic                       col_valid, prod_valid;
  logic [xfm_pkg::PROD_W-1:0] prod;
  logic [xfm_pkg::ELEM_W-1:0] result;

  // pipeline never holds an item off
  assign busy = 1'b0;

  xfm_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start),
    .f_flat    ({f_limb3, f_limb2, f_limb1, f_limb0}),
    .g_flat    ({g_limb3, g_limb2, g_limb1, g_limb0}),
    .valid_out (col_valid),
    .col       (col)
  );

  xfm_carry u_carry (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (col_valid),
    .col       (col),
    .valid_out (prod_valid),
    .prod      (prod)
  );

  xfm_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (prod_valid),
    .prod      (prod),
    .valid_out (done),
    .result    (result)
  );

  // split result into limbs
  assign product_limb0 = result[63:0];
  assign product_limb1 = result[127:64];
  assign product_limb2 = result[191:128];
  assign product_limb3 = result[255:192];

endmodule
